[rtl/core/mck_pkg.sv]
package mck_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] DotSamplesReset = 16'd2880;

  localparam logic [3:0] SpaceLen = 4'd15;
  localparam logic [7:0] SpaceChar = 8'h20;

  localparam logic [2:0] UnitsDot = 3'd1;
  localparam logic [2:0] UnitsDash = 3'd3;
  localparam logic [2:0] UnitsElemGap = 3'd1;
  localparam logic [2:0] UnitsCharGap = 3'd3;
  localparam logic [2:0] UnitsLineGap = 3'd4;
  localparam logic [2:0] UnitsWordGap = 3'd7;

  // Bits 15..12 hold the element count, bits 6..0 the elements (1 = dash).
  localparam logic [15:0] MORSE_TABLE [256] = '{
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h601E,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'hF000,16'h6031,16'h6012,16'h0000,16'h7009,16'h0000,16'h5008,16'h601E,
    16'h5016,16'h602D,16'h0000,16'h500A,16'h6033,16'h6021,16'h6015,16'h5012,
    16'h501F,16'h500F,16'h5007,16'h5003,16'h5001,16'h5000,16'h5010,16'h5018,
    16'h501C,16'h501E,16'h6038,16'h602A,16'h0000,16'h5011,16'h0000,16'h600C,
    16'h601A,16'h2001,16'h4008,16'h400A,16'h3004,16'h1000,16'h4002,16'h3006,
    16'h4000,16'h2000,16'h4007,16'h3005,16'h4004,16'h2003,16'h2002,16'h3007,
    16'h4006,16'h400D,16'h3002,16'h3000,16'h1001,16'h3001,16'h4001,16'h3003,
    16'h4009,16'h400B,16'h400C,16'h0000,16'h0000,16'h0000,16'h0000,16'h600D,
    16'h0000,16'h2001,16'h4008,16'h400A,16'h3004,16'h1000,16'h4002,16'h3006,
    16'h4000,16'h2000,16'h4007,16'h3005,16'h4004,16'h2003,16'h2002,16'h3007,
    16'h4006,16'h400D,16'h3002,16'h3000,16'h1001,16'h3001,16'h4001,16'h3003,
    16'h4009,16'h400B,16'h400C,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h3000,16'h0000,16'h3000,16'h1001,16'h400C,16'h400C,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h3000,16'h0000,16'h3000,16'h1001,16'h400C,16'h400C,
    16'h0000,16'h0000,16'h0000,16'h4004,16'h0000,16'h2001,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h3000,16'h0000,16'h0000,16'h0000,16'h0000,16'h400C,
    16'h0000,16'h0000,16'h0000,16'h4004,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h2001,16'h3000,16'h0000,16'h4004,16'h0000,16'h4004,16'h400C,
    16'h3002,16'h2001,16'h2001,16'h2001,16'h2001,16'h4004,16'h400A,16'h400A,
    16'h400A,16'h1000,16'h1000,16'h1000,16'h1000,16'h2000,16'h2000,16'h3004,
    16'h3004,16'h2002,16'h2002,16'h3007,16'h3007,16'h3007,16'h3007,16'h0000,
    16'h3002,16'h3001,16'h3001,16'h3001,16'h3001,16'h400B,16'h1001,16'h0000,
    16'h3002,16'h2001,16'h2001,16'h2001,16'h2001,16'h4004,16'h400A,16'h400A,
    16'h400A,16'h1000,16'h1000,16'h1000,16'h1000,16'h2000,16'h2000,16'h3004,
    16'h3004,16'h2002,16'h2002,16'h3007,16'h3007,16'h3007,16'h3007,16'h0000,
    16'h3002,16'h3001,16'h3001,16'h3001,16'h3001,16'h400B,16'h1001,16'h0000
  };

  // One classified character as handed from the front to the back.
  typedef struct packed {
    logic       is_space;
    logic [2:0] count;
    logic [6:0] elems;
    logic       char_gap;
    logic       line_gap;
  } desc_t;

  // Queue status seen by the back.
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } queue_head_t;

endpackage

[rtl/core/morse_character_keyer.sv]
// Channel  Direction  Handshake               Payload
// input    in         in_valid_i/in_stall_o   symbol_i, next_is_space_i, line_end_i
// output   out        out_valid_o/out_stall_i tone_on_o, units_o, duration_o, last_o
// config   in         cfg_we_i                cfg_wdata_i (dot_samples)
//
// The front classifies a character and pushes it into the queue at its accepting edge.
// The back loads it from the queue in its idle state and then emits one run per cycle
// while the output is not stalled; a character has 1 to 15 runs, and a byte with no run
// takes only its accepting cycle. Reset clears the queue, the sequencer and the output
// valid, and sets dot_samples to 2880. Input stalls only when the queue is full; a
// stalled output beat holds while the queue keeps taking characters.
module morse_character_keyer #(
  parameter int unsigned QueueDepth = mck_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic        next_is_space_i,
  input  logic        line_end_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tone_on_o,
  output logic [2:0]  units_o,
  output logic [18:0] duration_o,
  output logic        last_o
);
  import mck_pkg::*;

  // Samples per dot unit; the host must write it only while the keyer is idle, the block itself does not enforce this.
  logic [15:0] dot_samples_q;

  // The front classifies a byte into a descriptor and pushes it into the queue.
  logic        push;
  logic        full;
  desc_t       front_desc;
  queue_head_t head;
  logic        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_samples_q <= DotSamplesReset;
    end else if (cfg_we_i) begin
      dot_samples_q <= cfg_wdata_i;
    end
  end

  mck_front u_front (
    .in_valid_i      (in_valid_i),
    .symbol_i        (symbol_i),
    .next_is_space_i (next_is_space_i),
    .line_end_i      (line_end_i),
    .full_i          (full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .desc_o          (front_desc)
  );

  // The queue decouples the front from the back so each side stalls on its own.
  mck_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (front_desc),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  // The back walks the elements and gaps and emits one run beat at a time.
  mck_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dot_samples_i (dot_samples_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tone_on_o     (tone_on_o),
    .units_o       (units_o),
    .duration_o    (duration_o),
    .last_o        (last_o)
  );

endmodule

[rtl/core/mck_front.sv]
module mck_front (
  input  logic          in_valid_i,
  input  logic [7:0]    symbol_i,
  input  logic          next_is_space_i,
  input  logic          line_end_i,
  input  logic          full_i,
  output logic          in_stall_o,
  output logic          push_o,
  output mck_pkg::desc_t desc_o
);
  import mck_pkg::*;

  logic [15:0] word;
  logic [3:0]  count;
  logic        is_space;
  logic        has_elems;

  assign word      = MORSE_TABLE[symbol_i];
  assign count     = word[15:12];
  assign is_space  = (count == SpaceLen);
  assign has_elems = !is_space && (count != 4'd0);

  assign desc_o.is_space = is_space;
  assign desc_o.count    = has_elems ? count[2:0] : 3'd0;
  assign desc_o.elems    = word[6:0];
  assign desc_o.char_gap = has_elems && (symbol_i != SpaceChar) && !next_is_space_i;
  assign desc_o.line_gap = line_end_i;

  assign in_stall_o = full_i;
  // A byte with no code and no line end is accepted but yields no run.
  assign push_o = in_valid_i && !full_i && (is_space || has_elems || line_end_i);

endmodule

[rtl/core/mck_queue.sv]
module mck_queue #(
  parameter int unsigned Depth = mck_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mck_pkg::desc_t       desc_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output mck_pkg::queue_head_t head_o
);
  import mck_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.desc  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

[rtl/core/mck_back.sv]
module mck_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          dot_samples_i,
  input  mck_pkg::queue_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 tone_on_o,
  output logic [2:0]           units_o,
  output logic [18:0]          duration_o,
  output logic                 last_o
);
  import mck_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StElem = 3'd1;
  localparam logic [2:0] StChar = 3'd2;
  localparam logic [2:0] StWord = 3'd3;
  localparam logic [2:0] StLine = 3'd4;

  logic [2:0]  state_q, state_d;
  desc_t       desc_q, desc_d;
  logic [2:0]  k_q, k_d;
  logic        gap_q, gap_d;
  logic        out_valid_q, out_valid_d;
  logic        tone_q, tone_d;
  logic [2:0]  units_q, units_d;
  logic [18:0] dur_q, dur_d;
  logic        last_q, last_d;
  logic        fire;
  logic [2:0]  elem_idx;
  logic [2:0]  after_elems;

  assign fire        = (state_q != StIdle) && (!out_valid_q || !out_stall_i);
  assign pop_o       = (state_q == StIdle) && head_i.valid;
  assign elem_idx    = k_q - 3'd1;
  assign after_elems = desc_q.char_gap ? StChar : (desc_q.line_gap ? StLine : StIdle);

  always_comb begin
    state_d     = state_q;
    desc_d      = desc_q;
    k_d         = k_q;
    gap_d       = gap_q;
    out_valid_d = out_valid_q && out_stall_i;
    tone_d      = tone_q;
    units_d     = units_q;
    last_d      = last_q;

    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          desc_d = head_i.desc;
          k_d    = head_i.desc.count;
          gap_d  = 1'b0;
          if (head_i.desc.is_space) begin
            state_d = StWord;
          end else if (head_i.desc.count != 3'd0) begin
            state_d = StElem;
          end else begin
            state_d = StLine;
          end
        end
      end
      StElem: begin
        if (fire) begin
          out_valid_d = 1'b1;
          if (gap_q) begin
            tone_d  = 1'b0;
            units_d = UnitsElemGap;
            last_d  = 1'b0;
            gap_d   = 1'b0;
            k_d     = k_q - 3'd1;
          end else begin
            tone_d  = 1'b1;
            units_d = desc_q.elems[elem_idx] ? UnitsDash : UnitsDot;
            if (k_q != 3'd1) begin
              gap_d  = 1'b1;
              last_d = 1'b0;
            end else begin
              last_d  = (after_elems == StIdle);
              state_d = after_elems;
            end
          end
        end
      end
      StChar: begin
        if (fire) begin
          out_valid_d = 1'b1;
          tone_d      = 1'b0;
          units_d     = UnitsCharGap;
          last_d      = !desc_q.line_gap;
          state_d     = desc_q.line_gap ? StLine : StIdle;
        end
      end
      StWord: begin
        if (fire) begin
          out_valid_d = 1'b1;
          tone_d      = 1'b0;
          units_d     = UnitsWordGap;
          last_d      = !desc_q.line_gap;
          state_d     = desc_q.line_gap ? StLine : StIdle;
        end
      end
      StLine: begin
        if (fire) begin
          out_valid_d = 1'b1;
          tone_d      = 1'b0;
          units_d     = UnitsLineGap;
          last_d      = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Run length in samples; the product lands straight in the output register.
  assign dur_d = fire ? (19'(units_d) * 19'(dot_samples_i)) : dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q  <= desc_d;
    k_q     <= k_d;
    gap_q   <= gap_d;
    tone_q  <= tone_d;
    units_q <= units_d;
    dur_q   <= dur_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign tone_on_o   = tone_q;
  assign units_o     = units_q;
  assign duration_o  = dur_q;
  assign last_o      = last_q;

endmodule
